[hdl/aff_pkg.sv]
// ----------------------------------------------------------------------------
// aff_pkg: shared types and constants for the 2x3 affine inverse
// Fixed-point formats, divider lane layout and saturation limits.
// ----------------------------------------------------------------------------
package aff_pkg;

  // coefficient format, signed Q(32-FRAC_BITS).FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int SH1       = FRAC_BITS;
  localparam int SH2       = 2 * FRAC_BITS;

  // divider geometry: quotient bits, remainder and shifted numerator widths
  localparam int QUO_W     = COEF_W;
  localparam int REM_W     = PROD_W;
  localparam int NUM_W     = REM_W + QUO_W + FRAC_BITS;
  localparam int HI_W      = NUM_W - QUO_W;
  localparam int DIV_STEPS = QUO_W;

  // lanes, one per inverse coefficient, in output order
  localparam int NUM_LANES    = 6;
  localparam int LANE_SCALE_X = 0;
  localparam int LANE_SKEW_X  = 1;
  localparam int LANE_SHIFT_X = 2;
  localparam int LANE_SKEW_Y  = 3;
  localparam int LANE_SCALE_Y = 4;
  localparam int LANE_SHIFT_Y = 5;

  localparam logic [QUO_W-1:0] POS_SAT = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_SAT = {1'b1, {(QUO_W-1){1'b0}}};

  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [QUO_W-1:0]  coef_t;

  // one divider lane: partial remainder, dividend/quotient shift word, flags
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             neg;
  } lane_t;

  // item as it travels through the divider stages
  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic [REM_W-1:0]      dmag;
    logic                  zero;
  } div_t;

  // finished result item
  typedef struct packed {
    logic                  invertible;
    coef_t [NUM_LANES-1:0] coef;
  } res_t;

  function automatic logic [PROD_W-1:0] mag64(logic signed [PROD_W-1:0] x);
    return x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
  endfunction

  function automatic logic [COEF_W-1:0] mag32(logic signed [COEF_W-1:0] x);
    return x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
  endfunction

endpackage

[hdl/aff_in_if.sv]
// ----------------------------------------------------------------------------
// aff_in_if: input channel of the affine inverse
// Valid/ready handshake carrying the six matrix coefficients.
// ----------------------------------------------------------------------------
interface aff_in_if;
  import aff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] scale_x;
  logic signed [COEF_W-1:0] skew_x;
  logic signed [COEF_W-1:0] shift_x;
  logic signed [COEF_W-1:0] skew_y;
  logic signed [COEF_W-1:0] scale_y;
  logic signed [COEF_W-1:0] shift_y;

  modport source (
    output valid, scale_x, skew_x, shift_x, skew_y, scale_y, shift_y,
    input  ready
  );

  modport sink (
    input  valid, scale_x, skew_x, shift_x, skew_y, scale_y, shift_y,
    output ready
  );

endinterface

[hdl/aff_out_if.sv]
// ----------------------------------------------------------------------------
// aff_out_if: output channel of the affine inverse
// Valid/ready handshake carrying the inverse matrix and its invertible flag.
// ----------------------------------------------------------------------------
interface aff_out_if;
  import aff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     invertible;
  logic signed [COEF_W-1:0] inv_scale_x;
  logic signed [COEF_W-1:0] inv_skew_x;
  logic signed [COEF_W-1:0] inv_shift_x;
  logic signed [COEF_W-1:0] inv_skew_y;
  logic signed [COEF_W-1:0] inv_scale_y;
  logic signed [COEF_W-1:0] inv_shift_y;

  modport source (
    output valid, invertible, inv_scale_x, inv_skew_x, inv_shift_x,
           inv_skew_y, inv_scale_y, inv_shift_y,
    input  ready
  );

  modport sink (
    input  valid, invertible, inv_scale_x, inv_skew_x, inv_shift_x,
           inv_skew_y, inv_scale_y, inv_shift_y,
    output ready
  );

endinterface

[hdl/aff_prep.sv]
// ----------------------------------------------------------------------------
// aff_prep: products, determinant and divider setup
// Four register stages: six 32x32 products, exact differences, magnitudes
// with shifted numerators, then overflow test and initial remainders.
// ----------------------------------------------------------------------------
module aff_prep (
  input  logic         clk_i,
  input  logic         rst_ni,
  aff_in_if.sink       in_i,
  output logic         valid_o,
  input  logic         ready_i,
  output aff_pkg::div_t data_o
);
  import aff_pkg::*;

  localparam int NUM_STAGES = 4;
  localparam int NUM_PROD   = 6;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] adv;

  // stage 1: products a*e, b*d, b*f, c*e, c*d, a*f
  logic signed [PROD_W-1:0] prod_d [NUM_PROD];
  logic signed [PROD_W-1:0] prod_q [NUM_PROD];
  logic signed [COEF_W-1:0] a1_q, b1_q, d1_q, e1_q;

  // stage 2: determinant and translation numerators
  logic signed [PROD_W-1:0] det2_q, ntx2_q, nty2_q;
  logic signed [COEF_W-1:0] a2_q, b2_q, d2_q, e2_q;

  // stage 3: shifted numerator magnitudes and quotient signs
  num_t                     num3_d [NUM_LANES];
  num_t                     num3_q [NUM_LANES];
  logic [NUM_LANES-1:0]     nneg_d;
  logic [NUM_LANES-1:0]     neg3_q;
  logic [REM_W-1:0]         dmag3_q;
  logic                     zero3_q;

  // stage 4: divider entry
  lane_t [NUM_LANES-1:0]    lane_d;
  div_t                     data_q;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[3] = !v_q[3] || ready_i;
    adv[2] = !v_q[2] || adv[3];
    adv[1] = !v_q[1] || adv[2];
    adv[0] = !v_q[0] || adv[1];
  end

  assign in_i.ready = adv[0];
  assign valid_o    = v_q[3];
  assign data_o     = data_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_i.valid;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  // products, each operand sign-extended to the product width
  assign prod_d[0] = in_i.scale_x * in_i.scale_y;
  assign prod_d[1] = in_i.skew_x  * in_i.skew_y;
  assign prod_d[2] = in_i.skew_x  * in_i.shift_y;
  assign prod_d[3] = in_i.shift_x * in_i.scale_y;
  assign prod_d[4] = in_i.shift_x * in_i.skew_y;
  assign prod_d[5] = in_i.scale_x * in_i.shift_y;

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_i.valid) begin
      prod_q <= prod_d;
      a1_q   <= in_i.scale_x;
      b1_q   <= in_i.skew_x;
      d1_q   <= in_i.skew_y;
      e1_q   <= in_i.scale_y;
    end
  end

  // exact differences; each product lies within +/-2^62 so nothing wraps
  always_ff @(posedge clk_i) begin
    if (adv[1] && v_q[0]) begin
      det2_q <= prod_q[0] - prod_q[1];
      ntx2_q <= prod_q[2] - prod_q[3];
      nty2_q <= prod_q[4] - prod_q[5];
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      d2_q   <= d1_q;
      e2_q   <= e1_q;
    end
  end

  // numerator magnitudes; the negated lanes count as negative when b or d > 0
  always_comb begin
    num3_d[LANE_SCALE_X] = num_t'(mag32(e2_q)) << SH2;
    num3_d[LANE_SKEW_X]  = num_t'(mag32(b2_q)) << SH2;
    num3_d[LANE_SHIFT_X] = num_t'(mag64(ntx2_q)) << SH1;
    num3_d[LANE_SKEW_Y]  = num_t'(mag32(d2_q)) << SH2;
    num3_d[LANE_SCALE_Y] = num_t'(mag32(a2_q)) << SH2;
    num3_d[LANE_SHIFT_Y] = num_t'(mag64(nty2_q)) << SH1;

    nneg_d[LANE_SCALE_X] = e2_q[COEF_W-1];
    nneg_d[LANE_SKEW_X]  = !b2_q[COEF_W-1] && (b2_q != '0);
    nneg_d[LANE_SHIFT_X] = ntx2_q[PROD_W-1];
    nneg_d[LANE_SKEW_Y]  = !d2_q[COEF_W-1] && (d2_q != '0);
    nneg_d[LANE_SCALE_Y] = a2_q[COEF_W-1];
    nneg_d[LANE_SHIFT_Y] = nty2_q[PROD_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2] && v_q[1]) begin
      num3_q  <= num3_d;
      neg3_q  <= nneg_d ^ {NUM_LANES{det2_q[PROD_W-1]}};
      dmag3_q <= mag64(det2_q);
      zero3_q <= (det2_q == '0);
    end
  end

  // quotient >= 2^32 exactly when the numerator's upper part reaches dmag;
  // otherwise that upper part is the first partial remainder
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_d[g] = '{
      rem: num3_q[g][QUO_W+REM_W-1:QUO_W],
      quo: num3_q[g][QUO_W-1:0],
      ovf: (num3_q[g][NUM_W-1:QUO_W] >= HI_W'(dmag3_q)),
      neg: neg3_q[g]
    };
  end

  always_ff @(posedge clk_i) begin
    if (adv[3] && v_q[2]) begin
      data_q <= '{lane: lane_d, dmag: dmag3_q, zero: zero3_q};
    end
  end

endmodule

[hdl/aff_div_stage.sv]
// ----------------------------------------------------------------------------
// aff_div_stage: one restoring division step for all six lanes
// Shifts one dividend bit into each partial remainder, subtracts the
// determinant magnitude where it fits, and shifts in the quotient bit.
// ----------------------------------------------------------------------------
module aff_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  aff_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output aff_pkg::div_t data_o
);
  import aff_pkg::*;

  logic                  v_q;
  div_t                  data_q;
  lane_t [NUM_LANES-1:0] step_d;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign data_o  = data_q;

  // per-lane compare and subtract
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [REM_W:0] r2;
    logic [REM_W:0] diff;
    logic           fits;

    assign r2   = {data_i.lane[g].rem, data_i.lane[g].quo[QUO_W-1]};
    assign diff = r2 - {1'b0, data_i.dmag};
    assign fits = (r2 >= {1'b0, data_i.dmag});

    assign step_d[g] = '{
      rem: fits ? diff[REM_W-1:0] : r2[REM_W-1:0],
      quo: {data_i.lane[g].quo[QUO_W-2:0], fits},
      ovf: data_i.lane[g].ovf,
      neg: data_i.lane[g].neg
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= '{lane: step_d, dmag: data_i.dmag, zero: data_i.zero};
    end
  end

`ifndef SYNTHESIS
  // partial remainder stays below the divisor on lanes that did not overflow
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_rem_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q && !data_q.zero && !data_q.lane[g].ovf |->
        (data_q.lane[g].rem < data_q.dmag))
      else $error("aff_div_stage: remainder not below divisor");
  end

  // a stalled item stays put in this stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !ready_i |=> v_q && $stable(data_q))
    else $error("aff_div_stage: stalled item changed");

  // an item taken from upstream shows up as valid here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> v_q)
    else $error("aff_div_stage: accepted item dropped");
`endif

endmodule

[hdl/aff_post.sv]
// ----------------------------------------------------------------------------
// aff_post: sign, saturation and output register
// Applies quotient signs, clamps to the signed coefficient range, forces
// zeros for a singular matrix and holds the result item for the receiver.
// ----------------------------------------------------------------------------
module aff_post (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  aff_pkg::div_t data_i,
  aff_out_if.source     out_o
);
  import aff_pkg::*;

  logic v_q;
  res_t res_d;
  res_t res_q;

  // signed, saturated coefficient from a finished lane
  function automatic coef_t sat_coef(lane_t l);
    if (l.neg) begin
      if (l.ovf || (l.quo > NEG_SAT)) return NEG_SAT;
      return QUO_W'(-l.quo);
    end
    if (l.ovf || l.quo[QUO_W-1]) return POS_SAT;
    return l.quo;
  endfunction

  always_comb begin
    res_d.invertible = !data_i.zero;
    for (int k = 0; k < NUM_LANES; k++) begin
      res_d.coef[k] = data_i.zero ? '0 : sat_coef(data_i.lane[k]);
    end
  end

  assign ready_o = !v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  // output channel
  assign out_o.valid       = v_q;
  assign out_o.invertible  = res_q.invertible;
  assign out_o.inv_scale_x = res_q.coef[LANE_SCALE_X];
  assign out_o.inv_skew_x  = res_q.coef[LANE_SKEW_X];
  assign out_o.inv_shift_x = res_q.coef[LANE_SHIFT_X];
  assign out_o.inv_skew_y  = res_q.coef[LANE_SKEW_Y];
  assign out_o.inv_scale_y = res_q.coef[LANE_SCALE_Y];
  assign out_o.inv_shift_y = res_q.coef[LANE_SHIFT_Y];

endmodule

[hdl/affine_2x3_inverse.sv]
// ----------------------------------------------------------------------------
// affine_2x3_inverse: pipelined inverse of a 2D affine matrix
// Inverts [a b c; d e f] in signed Q16.16 with exact determinant,
// truncating division and saturation to Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one matrix per item (scale_x=a, skew_x=b, shift_x=c,
//   skew_y=d, scale_y=e, shift_y=f); out_o returns one result item per
//   matrix, in order: the invertible flag and the six inverse terms.
//   A singular matrix gives invertible = 0 and all terms zero.
// Pipeline: the result is offered after four setup stages (products,
//   differences, magnitudes, overflow test), 32 divider stages of one
//   quotient bit each, and the output register.
// Throughput: one item per cycle unless a stall holds it; all six quotients
//   share each divider stage, so a new matrix may enter on every clock.
// Stall: each stage holds its item while the next stage is full and held;
//   empty stages keep filling, so in_i.ready drops only once every stage
//   up to the input holds an item. Nothing is lost or repeated.
// Reset: rst_ni clears all valid bits asynchronously; the pipeline is
//   empty and ready right after reset is released.
// ----------------------------------------------------------------------------
module affine_2x3_inverse (
  input  logic      clk_i,
  input  logic      rst_ni,
  aff_in_if.sink    in_i,
  aff_out_if.source out_o
);
  import aff_pkg::*;

  logic [DIV_STEPS:0] chain_valid;
  logic [DIV_STEPS:0] chain_ready;
  div_t               chain_data [DIV_STEPS+1];

  // setup stages
  aff_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // divider pipeline, one quotient bit per stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    aff_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // saturation and output register
  aff_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[DIV_STEPS]),
    .ready_o (chain_ready[DIV_STEPS]),
    .data_i  (chain_data[DIV_STEPS]),
    .out_o   (out_o)
  );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for affine_2x3_inverse
// Drives 2x3 affine matrices over the input channel and checks every inverse
// item against a hand-written result or a bit-exact fixed-point predictor. A
// short table of directed matrices comes first, then random matrices from
// several families. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import aff_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 2000;  // cycles with no item accepted on either side
  localparam int DRAIN_CYCLES = 45;    // pipeline latency plus margin
  localparam int IDLE_PCT     = 26;

  // one input matrix, coefficients in port order
  typedef struct packed {
    coef_t scale_x;
    coef_t skew_x;
    coef_t shift_x;
    coef_t skew_y;
    coef_t scale_y;
    coef_t shift_y;
  } matrix_t;

  // directed table row; typed rows carry a hand-written result
  typedef struct {
    matrix_t m;
    bit      typed;
    res_t    want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  aff_in_if  mat_if ();
  aff_out_if inv_if ();

  affine_2x3_inverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (mat_if),
    .out_o  (inv_if)
  );

  res_t     inverse_q [$];
  dir_row_t directed [$];
  bit       steady;
  int       error_count;
  int       checked_count;
  int       singular_count;
  int       saturated_count;
  int       stall_cycles;
  res_t     got;
  res_t     want;
  bit       sat_hit;

  string lane_name [NUM_LANES] = '{"inv_scale_x", "inv_skew_x", "inv_shift_x",
                                   "inv_skew_y", "inv_scale_y", "inv_shift_y"};

  // clock
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // (num << sh) / den, truncated toward zero, saturated to signed 32 bits
  function automatic coef_t quotient_sat(logic signed [63:0] num, int unsigned sh,
                                         logic signed [63:0] den);
    logic [63:0]  nmag;
    logic [63:0]  dmag;
    logic [127:0] q;
    logic         neg;
    nmag = num[63] ? 64'(-num) : 64'(num);
    dmag = den[63] ? 64'(-den) : 64'(den);
    neg  = num[63] ^ den[63];
    q    = ({64'd0, nmag} << sh) / {64'd0, dmag};
    if (neg) begin
      if (q > 128'h8000_0000) return NEG_SAT;
      return coef_t'(-q);
    end
    if (q > 128'h7FFF_FFFF) return POS_SAT;
    return coef_t'(q);
  endfunction

  // inverse of [a b c; d e f] with exact 64-bit determinant and numerators
  function automatic res_t predict_inverse(matrix_t m);
    logic signed [63:0] a, b, c, d, e, f;
    logic signed [63:0] det;
    res_t               r;
    a = $signed(m.scale_x);
    b = $signed(m.skew_x);
    c = $signed(m.shift_x);
    d = $signed(m.skew_y);
    e = $signed(m.scale_y);
    f = $signed(m.shift_y);
    det = a * e - b * d;
    r = '0;
    if (det != 0) begin
      r.invertible              = 1'b1;
      r.coef[LANE_SCALE_X] = quotient_sat(e, SH2, det);
      r.coef[LANE_SKEW_X]  = quotient_sat(-b, SH2, det);
      r.coef[LANE_SHIFT_X] = quotient_sat(b * f - c * e, SH1, det);
      r.coef[LANE_SKEW_Y]  = quotient_sat(-d, SH2, det);
      r.coef[LANE_SCALE_Y] = quotient_sat(a, SH2, det);
      r.coef[LANE_SHIFT_Y] = quotient_sat(c * d - a * f, SH1, det);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic matrix_t mk_mat(coef_t a, coef_t b, coef_t c,
                                     coef_t d, coef_t e, coef_t f);
    matrix_t m;
    m.scale_x = a;
    m.skew_x  = b;
    m.shift_x = c;
    m.skew_y  = d;
    m.scale_y = e;
    m.shift_y = f;
    return m;
  endfunction

  function automatic res_t mk_res(logic inv, coef_t sx, coef_t kx, coef_t tx,
                                  coef_t ky, coef_t sy, coef_t ty);
    res_t r;
    r.invertible         = inv;
    r.coef[LANE_SCALE_X] = sx;
    r.coef[LANE_SKEW_X]  = kx;
    r.coef[LANE_SHIFT_X] = tx;
    r.coef[LANE_SKEW_Y]  = ky;
    r.coef[LANE_SCALE_Y] = sy;
    r.coef[LANE_SHIFT_Y] = ty;
    return r;
  endfunction

  function automatic void add_row(matrix_t m, bit typed, res_t r);
    dir_row_t row;
    row.m     = m;
    row.typed = typed;
    row.want  = r;
    directed.push_back(row);
  endfunction

  // signed value spanning nbits bits
  function automatic coef_t rand_bits(int unsigned nbits);
    return coef_t'($signed($urandom) >>> (32 - nbits));
  endfunction

  function automatic coef_t rand_edge();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return 32'h7FFF_FFFF;
      6: return 32'h8000_0000;
      7: return 32'h7FFF_0000;
      8: return 32'h0000_8000;
      default: return coef_t'($urandom);
    endcase
  endfunction

  // random matrix drawn from one of several families
  function automatic matrix_t rand_matrix();
    matrix_t     m;
    int unsigned pick;
    int          s;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      m = mk_mat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 50) begin
      // everyday transforms: scale and skew within +/-32 units, any translation
      m = mk_mat(rand_bits($urandom_range(14, 22)), rand_bits($urandom_range(14, 22)),
                 rand_bits($urandom_range(16, 32)), rand_bits($urandom_range(14, 22)),
                 rand_bits($urandom_range(14, 22)), rand_bits($urandom_range(16, 32)));
    end else if (pick < 65) begin
      // singular: proportional rows or a zero column
      m = mk_mat(rand_bits(18), rand_bits(18), $urandom, 0, 0, $urandom);
      s = int'($urandom_range(0, 8)) - 4;
      m.skew_y  = coef_t'($signed(m.scale_x) * s);
      m.scale_y = coef_t'($signed(m.skew_x) * s);
      if ($urandom_range(0, 3) == 0) begin
        m.scale_x = '0;
        m.skew_y  = '0;
        m.skew_x  = $urandom;
        m.scale_y = $urandom;
      end
    end else if (pick < 80) begin
      m = mk_mat(rand_edge(), rand_edge(), rand_edge(),
                 rand_edge(), rand_edge(), rand_edge());
    end else begin
      // tiny determinant, pushes quotients into saturation
      m = mk_mat(rand_bits($urandom_range(1, 10)), rand_bits($urandom_range(1, 10)),
                 rand_bits($urandom_range(8, 32)), rand_bits($urandom_range(1, 10)),
                 rand_bits($urandom_range(1, 10)), rand_bits($urandom_range(8, 32)));
    end
    return m;
  endfunction

  // offer one matrix, with random idle cycles ahead of it
  task automatic send_matrix(matrix_t m, res_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      mat_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    mat_if.valid   <= 1'b1;
    mat_if.scale_x <= m.scale_x;
    mat_if.skew_x  <= m.skew_x;
    mat_if.shift_x <= m.shift_x;
    mat_if.skew_y  <= m.skew_y;
    mat_if.scale_y <= m.scale_y;
    mat_if.shift_y <= m.shift_y;
    do @(posedge clk_i); while (!mat_if.ready);
    inverse_q.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", checked_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (inv_if.valid && inv_if.ready) begin
        got = mk_res(inv_if.invertible, inv_if.inv_scale_x, inv_if.inv_skew_x,
                     inv_if.inv_shift_x, inv_if.inv_skew_y, inv_if.inv_scale_y,
                     inv_if.inv_shift_y);
        if (inverse_q.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          want = inverse_q.pop_front();
          if (got.invertible !== want.invertible)
            report_mismatch($sformatf("invertible got %b want %b",
                                      got.invertible, want.invertible));
          sat_hit = 1'b0;
          for (int k = 0; k < NUM_LANES; k++) begin
            if (got.coef[k] !== want.coef[k])
              report_mismatch($sformatf("%s got %h want %h",
                                        lane_name[k], got.coef[k], want.coef[k]));
            if (want.coef[k] == POS_SAT || want.coef[k] == NEG_SAT) sat_hit = 1'b1;
          end
          if (!want.invertible) singular_count++;
          if (sat_hit) saturated_count++;
        end
        checked_count++;
      end
      inv_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item accepted for %0d cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    steady         = 1'b0;
    error_count    = 0;
    checked_count  = 0;
    stall_cycles   = 0;
    mat_if.valid   = 1'b0;
    mat_if.scale_x = '0;
    mat_if.skew_x  = '0;
    mat_if.shift_x = '0;
    mat_if.skew_y  = '0;
    mat_if.scale_y = '0;
    mat_if.shift_y = '0;
    inv_if.ready   = 1'b0;

    // identity, plain and with translation
    add_row(mk_mat(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0), 1,
            mk_res(1, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0));
    add_row(mk_mat(32'h0001_0000, 0, 32'h0003_0000, 0, 32'h0001_0000, 32'hFFFE_0000), 1,
            mk_res(1, 32'h0001_0000, 0, 32'hFFFD_0000, 0, 32'h0001_0000, 32'h0002_0000));
    // singular: zero, all most negative, all most positive, proportional rows
    add_row(mk_mat(0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_mat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_mat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_mat(32'h0001_0000, 32'h0002_0000, 32'h1234_5678,
                   32'h0002_0000, 32'h0004_0000, 32'h8765_4321), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0));
    // one-LSB determinant saturates positive and negative
    add_row(mk_mat(1, 0, 0, 0, 1, 0), 1, mk_res(1, POS_SAT, 0, 0, 0, POS_SAT, 0));
    add_row(mk_mat(32'hFFFF_FFFF, 0, 0, 0, 1, 0), 1,
            mk_res(1, NEG_SAT, 0, 0, 0, POS_SAT, 0));
    // axis swap, scale by two, scale by minus one
    add_row(mk_mat(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0), 1,
            mk_res(1, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0));
    add_row(mk_mat(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 0), 1,
            mk_res(1, 32'h0000_8000, 0, 0, 0, 32'h0000_8000, 0));
    add_row(mk_mat(32'hFFFF_0000, 0, 0, 0, 32'hFFFF_0000, 0), 1,
            mk_res(1, 32'hFFFF_0000, 0, 0, 0, 32'hFFFF_0000, 0));
    // extremes, truncation and saturation checked against the predictor
    add_row(mk_mat(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000), 0, '0);
    add_row(mk_mat(32'h7FFF_FFFF, 1, 0, 0, 32'h7FFF_FFFF, 0), 0, '0);
    add_row(mk_mat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0, '0);
    add_row(mk_mat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, '0);
    add_row(mk_mat(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000), 0, '0);
    add_row(mk_mat(32'h0001_8000, 32'h0000_8000, 32'h0005_0000,
                   32'hFFFF_C000, 32'h0001_0000, 32'hFFFD_0000), 0, '0);
    add_row(mk_mat(0, 32'hFFFF_0000, 32'h0001_2345, 32'h0001_0000, 0, 32'h0006_789A), 0, '0);
    add_row(mk_mat(1, 0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000), 0, '0);
    add_row(mk_mat(32'h0000_0100, 0, 32'hFFFF_FFFF, 0, 32'h0000_0100, 1), 0, '0);
    add_row(mk_mat(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 0, '0);
    add_row(mk_mat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed[i])
      send_matrix(directed[i].m,
                  directed[i].typed ? directed[i].want : predict_inverse(directed[i].m));

    // hold off until the pipeline has drained
    mat_if.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);

    // random matrices, with a stretch of back-to-back traffic in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      matrix_t m;
      steady = (n >= 700 && n < 1000);
      if (n == 1300) begin
        mat_if.valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge clk_i);
      end
      m = rand_matrix();
      send_matrix(m, predict_inverse(m));
    end
    steady = 1'b0;
    mat_if.valid <= 1'b0;

    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d inverse items (%0d directed), %0d singular, %0d saturated",
             checked_count, directed.size(), singular_count, saturated_count);
    $display("random families: full range, near-unit, singular, edge values, tiny det");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
